[sv/bba_pkg.sv]
package bba_pkg;

    localparam int MAX_ORDER  = 7;
    localparam int POOL_UNITS = 1 << MAX_ORDER;
    localparam int ADDR_W     = MAX_ORDER;
    localparam int LINK_W     = ADDR_W + 1;
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int NUM_ORDERS = MAX_ORDER + 1;

    localparam int LEN_W      = 20;
    localparam int UNIT_W     = 13;
    localparam int HDR_W      = 7;
    localparam int TOTAL_W    = LEN_W + 1;
    localparam int CAP_W      = UNIT_W + MAX_ORDER;
    localparam int CMP_W      = (TOTAL_W > CAP_W) ? TOTAL_W : CAP_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = UNIT_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_BYTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'd1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_SPACE = 1'b1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_UNITS);

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(128);
    localparam logic [HDR_W-1:0]  HDR_RESET  = HDR_W'(16);

    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             free;
        logic             start;
    } meta_t;

    localparam int META_W = $bits(meta_t);

endpackage

[sv/bba_req_if.sv]
interface bba_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [bba_pkg::LEN_W-1:0]        req_length;
    logic [bba_pkg::ADDR_W-1:0]       free_offset;

    modport source (output valid, op, req_length, free_offset, input ready);
    modport sink   (input valid, op, req_length, free_offset, output ready);
endinterface

[sv/bba_rsp_if.sv]
interface bba_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             status;
    logic [bba_pkg::ADDR_W-1:0]       grant_offset;
    logic [bba_pkg::ORD_W-1:0]        grant_order;

    modport source (output valid, status, grant_offset, grant_order, input ready);
    modport sink   (input valid, status, grant_offset, grant_order, output ready);
endinterface

[sv/bba_ram.sv]
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/buddy_block_allocator.sv]
// Channel | Dir | Payload                                 | Handshake
// req     | in  | op, req_length, free_offset             | valid/ready
// rsp     | out | status, grant_offset, grant_order       | valid/ready
// cfg     | in  | cfg_index, cfg_wdata                    | cfg_we
//
// One transaction at a time; ready is high only in the idle cycle.
// Allocate: sizing, free-list scan, a pop and split per level, then take/out;
// no_space when the request exceeds the pool or no list holds a large-enough block.
// Free: check, a buddy read and merge per level, then push/out; ignored frees go to out.
// After reset a clearing pass initialises the RAMs.
// A finished result waits in the output register while rsp is stalled.
module buddy_block_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    bba_req_if.sink                         req,
    bba_rsp_if.source                       rsp
);
    import bba_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SIZE  = 4'd2;
    localparam logic [3:0] S_FIND  = 4'd3;
    localparam logic [3:0] S_POP0  = 4'd4;
    localparam logic [3:0] S_POP1  = 4'd5;
    localparam logic [3:0] S_SPLA  = 4'd6;
    localparam logic [3:0] S_SPLB  = 4'd7;
    localparam logic [3:0] S_TAKE  = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FCHK  = 4'd10;
    localparam logic [3:0] S_LVL   = 4'd11;
    localparam logic [3:0] S_BUD   = 4'd12;
    localparam logic [3:0] S_MRG   = 4'd13;
    localparam logic [3:0] S_PSH0  = 4'd14;
    localparam logic [3:0] S_PSH1  = 4'd15;

    logic [4:0]            state_reg, state_next;
    localparam logic [4:0] S_OUT = 5'd16;

    logic [UNIT_W-1:0]     unit_reg;
    logic [HDR_W-1:0]      hdr_reg;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [ORD_W-1:0]      ord_reg, ord_next;
    logic [ORD_W-1:0]      want_reg, want_next;
    logic [ADDR_W-1:0]     blk_reg, blk_next;
    logic [ADDR_W-1:0]     bud_reg, bud_next;
    logic [CMP_W-1:0]      total_reg, total_next;
    logic [CMP_W-1:0]      cap_reg, cap_next;
    logic [LINK_W-1:0]     head_reg [NUM_ORDERS];
    logic                  head_we;
    logic [ORD_W-1:0]      head_idx;
    logic [LINK_W-1:0]     head_wdata;
    logic                  res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     res_off_reg, res_off_next;
    logic [ORD_W-1:0]      res_ord_reg, res_ord_next;
    logic                  out_valid_reg;
    logic                  out_status_reg;
    logic [ADDR_W-1:0]     out_off_reg;
    logic [ORD_W-1:0]      out_ord_reg;

    logic                  meta_we;
    logic [ADDR_W-1:0]     meta_waddr, meta_raddr;
    meta_t                 meta_wdata, meta_rdata;
    logic [META_W-1:0]     meta_rbits;
    logic                  next_we;
    logic [ADDR_W-1:0]     next_waddr, next_raddr;
    logic [LINK_W-1:0]     next_wdata, next_rdata;
    logic                  prev_we;
    logic [ADDR_W-1:0]     prev_waddr, prev_raddr;
    logic [LINK_W-1:0]     prev_wdata, prev_rdata;

    logic [LINK_W-1:0]     head_cur;
    logic [ADDR_W-1:0]     ord_bit;
    logic                  load_out;

    assign meta_rdata = meta_t'(meta_rbits);
    assign head_cur   = head_reg[ord_reg];
    assign ord_bit    = ADDR_W'(1) << ord_reg;
    assign load_out   = (state_reg == S_OUT) && (!out_valid_reg || rsp.ready);

    assign req.ready        = (state_reg == {1'b0, S_IDLE});
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.grant_offset = out_off_reg;
    assign rsp.grant_order  = out_ord_reg;

    bba_ram #(.WIDTH(META_W), .DEPTH(POOL_UNITS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (meta_raddr),
        .rdata (meta_rbits)
    );

    bba_ram #(.WIDTH(LINK_W), .DEPTH(POOL_UNITS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_rdata)
    );

    bba_ram #(.WIDTH(LINK_W), .DEPTH(POOL_UNITS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ord_next        = ord_reg;
        want_next       = want_reg;
        blk_next        = blk_reg;
        bud_next        = bud_reg;
        total_next      = total_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_ord_next    = res_ord_reg;
        head_we         = 1'b0;
        head_idx        = ord_reg;
        head_wdata      = NIL;
        meta_we         = 1'b0;
        meta_waddr      = blk_reg;
        meta_wdata      = '0;
        meta_raddr      = blk_reg;
        next_we         = 1'b0;
        next_waddr      = blk_reg;
        next_wdata      = NIL;
        next_raddr      = blk_reg;
        prev_we         = 1'b0;
        prev_waddr      = blk_reg;
        prev_wdata      = NIL;
        prev_raddr      = blk_reg;

        case (state_reg)
            {1'b0, S_CLEAR}:
            begin
                meta_we    = 1'b1;
                meta_waddr = cnt_reg;
                if (cnt_reg == '0)
                begin
                    meta_wdata = '{order: ORD_W'(MAX_ORDER), free: 1'b1, start: 1'b1};
                end
                next_we    = 1'b1;
                next_waddr = cnt_reg;
                prev_we    = 1'b1;
                prev_waddr = cnt_reg;
                cnt_next   = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(POOL_UNITS - 1))
                begin
                    state_next = {1'b0, S_IDLE};
                end
            end
            {1'b0, S_IDLE}:
            begin
                res_status_next = ST_OK;
                res_off_next    = '0;
                res_ord_next    = '0;
                if (req.valid)
                begin
                    ord_next   = '0;
                    blk_next   = req.free_offset;
                    total_next = CMP_W'(req.req_length) + CMP_W'(hdr_reg);
                    cap_next   = (unit_reg == '0) ? CMP_W'(1) : CMP_W'(unit_reg);
                    state_next = (req.op == OP_FREE) ? {1'b0, S_FRD} : {1'b0, S_SIZE};
                end
            end
            {1'b0, S_SIZE}:
            begin
                if (total_reg <= cap_reg)
                begin
                    want_next  = ord_reg;
                    state_next = {1'b0, S_FIND};
                end
                else if (ord_reg == ORD_W'(MAX_ORDER))
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_OUT;
                end
                else
                begin
                    ord_next = ord_reg + ORD_W'(1);
                    cap_next = cap_reg << 1;
                end
            end
            {1'b0, S_FIND}:
            begin
                if (head_cur != NIL)
                begin
                    state_next = {1'b0, S_POP0};
                end
                else if (ord_reg == ORD_W'(MAX_ORDER))
                begin
                    res_status_next = ST_NO_SPACE;
                    state_next      = S_OUT;
                end
                else
                begin
                    ord_next = ord_reg + ORD_W'(1);
                end
            end
            {1'b0, S_POP0}:
            begin
                blk_next   = head_cur[ADDR_W-1:0];
                next_raddr = head_cur[ADDR_W-1:0];
                state_next = {1'b0, S_POP1};
            end
            {1'b0, S_POP1}:
            begin
                head_we    = 1'b1;
                head_wdata = next_rdata;
                if (next_rdata != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata[ADDR_W-1:0];
                end
                if (ord_reg != want_reg)
                begin
                    ord_next   = ord_reg - ORD_W'(1);
                    state_next = {1'b0, S_SPLA};
                end
                else
                begin
                    state_next = {1'b0, S_TAKE};
                end
            end
            {1'b0, S_SPLA}:
            begin
                // lower half; its list neighbour below is known empty
                meta_we    = 1'b1;
                meta_wdata = '{order: ord_reg, free: 1'b1, start: 1'b1};
                next_we    = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = {1'b0, blk_reg | ord_bit};
                state_next = {1'b0, S_SPLB};
            end
            {1'b0, S_SPLB}:
            begin
                meta_we    = 1'b1;
                meta_waddr = blk_reg | ord_bit;
                meta_wdata = '{order: ord_reg, free: 1'b1, start: 1'b1};
                next_we    = 1'b1;
                next_waddr = blk_reg | ord_bit;
                next_wdata = {1'b0, blk_reg};
                prev_we    = 1'b1;
                prev_waddr = blk_reg | ord_bit;
                head_we    = 1'b1;
                head_wdata = {1'b0, blk_reg | ord_bit};
                state_next = {1'b0, S_POP0};
            end
            {1'b0, S_TAKE}:
            begin
                meta_we      = 1'b1;
                meta_wdata   = '{order: want_reg, free: 1'b0, start: 1'b1};
                res_off_next = blk_reg;
                res_ord_next = want_reg;
                state_next   = S_OUT;
            end
            {1'b0, S_FRD}:
            begin
                state_next = {1'b0, S_FCHK};
            end
            {1'b0, S_FCHK}:
            begin
                if (meta_rdata.start && !meta_rdata.free)
                begin
                    ord_next   = meta_rdata.order;
                    state_next = {1'b0, S_LVL};
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            {1'b0, S_LVL}:
            begin
                if (ord_reg >= ORD_W'(MAX_ORDER))
                begin
                    state_next = {1'b0, S_PSH0};
                end
                else
                begin
                    bud_next   = blk_reg ^ ord_bit;
                    meta_raddr = blk_reg ^ ord_bit;
                    state_next = {1'b0, S_BUD};
                end
            end
            {1'b0, S_BUD}:
            begin
                next_raddr = bud_reg;
                prev_raddr = bud_reg;
                if (meta_rdata.start && meta_rdata.free && meta_rdata.order == ord_reg)
                begin
                    state_next = {1'b0, S_MRG};
                end
                else
                begin
                    state_next = {1'b0, S_PSH0};
                end
            end
            {1'b0, S_MRG}:
            begin
                // unlink the buddy and drop the upper half
                if (prev_rdata != NIL)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata[ADDR_W-1:0];
                    next_wdata = next_rdata;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_wdata = next_rdata;
                end
                if (next_rdata != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata[ADDR_W-1:0];
                    prev_wdata = prev_rdata;
                end
                meta_we    = 1'b1;
                meta_waddr = blk_reg | bud_reg;
                blk_next   = blk_reg & bud_reg;
                ord_next   = ord_reg + ORD_W'(1);
                state_next = {1'b0, S_LVL};
            end
            {1'b0, S_PSH0}:
            begin
                meta_we    = 1'b1;
                meta_wdata = '{order: ord_reg, free: 1'b1, start: 1'b1};
                next_we    = 1'b1;
                next_wdata = head_cur;
                prev_we    = 1'b1;
                state_next = {1'b0, S_PSH1};
            end
            {1'b0, S_PSH1}:
            begin
                if (head_cur != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = head_cur[ADDR_W-1:0];
                    prev_wdata = {1'b0, blk_reg};
                end
                head_we    = 1'b1;
                head_wdata = {1'b0, blk_reg};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = {1'b0, S_IDLE};
                end
            end
            default:
            begin
                state_next = {1'b0, S_IDLE};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= {1'b0, S_CLEAR};
            cnt_reg       <= '0;
            unit_reg      <= UNIT_RESET;
            hdr_reg       <= HDR_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                head_reg[i] <= (i == MAX_ORDER) ? LINK_W'(0) : NIL;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && cfg_index == REG_UNIT_BYTES)
            begin
                unit_reg <= cfg_wdata[UNIT_W-1:0];
            end
            if (cfg_we && cfg_index == REG_HEADER_BYTES)
            begin
                hdr_reg <= cfg_wdata[HDR_W-1:0];
            end
            if (head_we)
            begin
                head_reg[head_idx] <= head_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg        <= ord_next;
        want_reg       <= want_next;
        blk_reg        <= blk_next;
        bud_reg        <= bud_next;
        total_reg      <= total_next;
        cap_reg        <= cap_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_ord_reg    <= res_ord_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_ord_reg    <= res_ord_reg;
        end
    end
endmodule

[sv/bba_checker.sv]
module bba_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic                        rsp_status,
    input  logic [bba_pkg::ADDR_W-1:0]  rsp_offset,
    input  logic [bba_pkg::ORD_W-1:0]   rsp_order
);
    import bba_pkg::*;

    logic [ADDR_W-1:0] align_mask;
    assign align_mask = (ADDR_W'(1) << rsp_order) - ADDR_W'(1);

    // one transaction in flight: ready drops after acceptance
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_NO_SPACE |-> rsp_offset == '0 && rsp_order == '0)
        else $error("no_space with non-zero grant");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_offset & align_mask) == '0)
        else $error("grant not aligned to its order");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset) && $stable(rsp_order))
        else $error("response dropped while stalled");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_offset (rsp.grant_offset),
    .rsp_order  (rsp.grant_order)
);

[test/buddy_block_allocator_tb.sv]
module buddy_block_allocator_tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] offset;
        logic [ORD_W-1:0]  order;
    } grant_t;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [LEN_W-1:0]      len;
        logic [ADDR_W-1:0]     off;
        bit                    fixed;
        grant_t                want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bba_req_if req ();
    bba_rsp_if rsp ();

    buddy_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // allocator mirror
    logic [UNIT_W-1:0] unit_sz;
    logic [HDR_W-1:0]  hdr_sz;
    logic [ORD_W-1:0]  blk_ord   [POOL_UNITS];
    bit                blk_free  [POOL_UNITS];
    bit                blk_start [POOL_UNITS];
    logic [LINK_W-1:0] fl_next   [POOL_UNITS];
    logic [LINK_W-1:0] fl_prev   [POOL_UNITS];
    logic [LINK_W-1:0] fl_head   [NUM_ORDERS];

    grant_t grant_q[$];
    int     live_q[$];
    int     errors;
    int     cycles;
    bit     long_hold;
    bit     burst;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void mirror_reset();
        unit_sz = UNIT_RESET;
        hdr_sz  = HDR_RESET;
        for (int i = 0; i < POOL_UNITS; i++)
        begin
            blk_ord[i]   = '0;
            blk_free[i]  = 1'b0;
            blk_start[i] = 1'b0;
            fl_next[i]   = NIL;
            fl_prev[i]   = NIL;
        end
        for (int i = 0; i < NUM_ORDERS; i++)
            fl_head[i] = NIL;
        blk_ord[0]   = ORD_W'(MAX_ORDER);
        blk_free[0]  = 1'b1;
        blk_start[0] = 1'b1;
        fl_head[MAX_ORDER] = '0;
    endfunction

    function automatic void list_push(int ord, int blk);
        logic [LINK_W-1:0] h;
        h = fl_head[ord];
        fl_prev[blk] = NIL;
        fl_next[blk] = h;
        if (h != NIL)
            fl_prev[h[ADDR_W-1:0]] = LINK_W'(blk);
        fl_head[ord] = LINK_W'(blk);
    endfunction

    function automatic void list_unlink(int ord, int blk);
        logic [LINK_W-1:0] p;
        logic [LINK_W-1:0] n;
        p = fl_prev[blk];
        n = fl_next[blk];
        if (p != NIL)
            fl_next[p[ADDR_W-1:0]] = n;
        else
            fl_head[ord] = n;
        if (n != NIL)
            fl_prev[n[ADDR_W-1:0]] = p;
        fl_prev[blk] = NIL;
        fl_next[blk] = NIL;
    endfunction

    function automatic grant_t predict_alloc(logic [LEN_W-1:0] len);
        grant_t g;
        longint unsigned total;
        longint unsigned u;
        longint unsigned units;
        int want;
        int ord;
        int blk;
        int hi;
        g = '0;
        total = longint'(len) + longint'(hdr_sz);
        u = (unit_sz == 0) ? 1 : longint'(unit_sz);
        units = (total + u - 1) / u;
        want = 0;
        while (want <= MAX_ORDER && (64'd1 << want) < units)
            want++;
        if (want > MAX_ORDER)
        begin
            g.status = ST_NO_SPACE;
            return g;
        end
        ord = want;
        while (ord <= MAX_ORDER && fl_head[ord] == NIL)
            ord++;
        if (ord > MAX_ORDER)
        begin
            g.status = ST_NO_SPACE;
            return g;
        end
        while (ord > want)
        begin
            blk = int'(fl_head[ord]);
            list_unlink(ord, blk);
            ord--;
            hi = blk + (1 << ord);
            blk_ord[blk] = ORD_W'(ord); blk_free[blk] = 1'b1; blk_start[blk] = 1'b1;
            blk_ord[hi]  = ORD_W'(ord); blk_free[hi]  = 1'b1; blk_start[hi]  = 1'b1;
            list_push(ord, blk);
            list_push(ord, hi);
        end
        blk = int'(fl_head[want]);
        list_unlink(want, blk);
        blk_free[blk] = 1'b0;
        g.status = ST_OK;
        g.offset = ADDR_W'(blk);
        g.order  = ORD_W'(want);
        return g;
    endfunction

    function automatic void predict_free(logic [ADDR_W-1:0] off);
        int blk;
        int ord;
        int bud;
        blk = int'(off);
        if (!blk_start[blk] || blk_free[blk])
            return;
        ord = int'(blk_ord[blk]);
        forever
        begin
            blk_free[blk] = 1'b1;
            if (ord >= MAX_ORDER)
            begin
                list_push(MAX_ORDER, blk);
                return;
            end
            bud = blk ^ (1 << ord);
            if (blk_start[bud] && blk_free[bud] && int'(blk_ord[bud]) == ord)
            begin
                list_unlink(ord, bud);
                if (bud > blk)
                begin
                    blk_start[bud] = 1'b0; blk_free[bud] = 1'b0; blk_ord[bud] = '0;
                end
                else
                begin
                    blk_start[blk] = 1'b0; blk_free[blk] = 1'b0; blk_ord[blk] = '0;
                    blk = bud;
                end
                ord++;
                blk_ord[blk] = ORD_W'(ord);
            end
            else
            begin
                list_push(ord, blk);
                return;
            end
        end
    endfunction

    task automatic wait_drained();
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_UNIT_BYTES)
            unit_sz = UNIT_W'(data);
        else
            hdr_sz = HDR_W'(data);
    endtask

    task automatic send_txn(logic op, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] off,
                            bit fixed, grant_t fixed_grant);
        int gap;
        grant_t g;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.op          <= op;
        req.req_length  <= len;
        req.free_offset <= off;
        do
            @(posedge clk);
        while (!req.ready);
        g = '0;
        if (op == OP_ALLOC)
        begin
            g = predict_alloc(len);
            if (g.status == ST_OK)
                live_q = {live_q, int'(g.offset)};
        end
        else
        begin
            predict_free(off);
            for (int i = 0; i < live_q.size(); i++)
                if (live_q[i] == int'(off))
                begin
                    live_q.delete(i);
                    break;
                end
        end
        grant_q = {grant_q, (fixed ? fixed_grant : g)};
    endtask

    task automatic random_txn();
        int r;
        int k;
        longint unsigned cap;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 48)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
            cap = ((unit_sz == 0) ? 1 : longint'(unit_sz)) << k;
            if (cap > 1048575)
                cap = 1048575;
            len = LEN_W'($urandom_range(0, int'(cap)));
            send_txn(OP_ALLOC, len, ADDR_W'($urandom), 1'b0, '0);
        end
        else if (r < 86 && live_q.size() != 0)
            send_txn(OP_FREE, LEN_W'($urandom),
                     ADDR_W'(live_q[$urandom_range(0, live_q.size() - 1)]), 1'b0, '0);
        else if (r < 93)
            send_txn(OP_FREE, LEN_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
        else
            send_txn(OP_ALLOC, LEN_W'($urandom), ADDR_W'($urandom), 1'b0, '0);
    endtask

    // receiver
    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                n = LONG_HOLD;
                long_hold = 1'b0;
            end
            else
                n = burst ? 0 : $urandom_range(0, 10);
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    always @(posedge clk)
    begin
        grant_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (grant_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected transaction: status %0b offset %0d order %0d",
                             rsp.status, rsp.grant_offset, rsp.grant_order);
            end
            else
            begin
                w = grant_q.pop_front();
                if (rsp.status !== w.status || rsp.grant_offset !== w.offset ||
                    rsp.grant_order !== w.order)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0b/%0d/%0d got %0b/%0d/%0d",
                                 w.status, w.offset, w.order,
                                 rsp.status, rsp.grant_offset, rsp.grant_order);
                end
            end
        end
    end

    function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int data);
        row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = CFG_DATA_W'(data);
        r.op    = OP_ALLOC;
        r.len   = '0;
        r.off   = '0;
        r.fixed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t req_row(logic op, int len, int off, bit fixed, grant_t g);
        row_t r;
        r.kind  = ROW_REQ;
        r.idx   = '0;
        r.data  = '0;
        r.op    = op;
        r.len   = LEN_W'(len);
        r.off   = ADDR_W'(off);
        r.fixed = fixed;
        r.want  = g;
        return r;
    endfunction

    initial
    begin
        row_t rows[$];
        grant_t none;
        grant_t full;
        int unit_tbl[5];
        int hdr_tbl[5];
        none = '0;
        full = '0;
        full.status = ST_NO_SPACE;
        unit_tbl = '{128, 1, 4096, 37, 8191};
        hdr_tbl  = '{16, 0, 64, 5, 127};
        errors = 0;
        cycles = 0;
        long_hold = 1'b0;
        burst = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.op = OP_ALLOC;
        req.req_length = '0;
        req.free_offset = '0;
        mirror_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = {rows, req_row(OP_ALLOC, 1048575, 0, 1, full)};
        rows = {rows, req_row(OP_FREE, 0, 5, 1, none)};
        rows = {rows, req_row(OP_FREE, 0, 127, 1, none)};
        rows = {rows, req_row(OP_ALLOC, 0, 0, 0, none)};
        rows = {rows, req_row(OP_ALLOC, 16368, 0, 0, none)};
        rows = {rows, req_row(OP_ALLOC, 100, 0, 0, none)};
        rows = {rows, req_row(OP_ALLOC, 1000, 0, 0, none)};
        rows = {rows, req_row(OP_FREE, 0, 127, 0, none)};
        rows = {rows, req_row(OP_FREE, 0, 127, 1, none)};
        rows = {rows, cfg_row(REG_UNIT_BYTES, 1)};
        rows = {rows, cfg_row(REG_HEADER_BYTES, 0)};
        rows = {rows, req_row(OP_ALLOC, 0, 0, 0, none)};
        rows = {rows, req_row(OP_ALLOC, 129, 0, 1, full)};
        rows = {rows, req_row(OP_ALLOC, 64, 0, 0, none)};
        rows = {rows, cfg_row(REG_UNIT_BYTES, 0)};
        rows = {rows, req_row(OP_ALLOC, 5, 0, 0, none)};
        rows = {rows, cfg_row(REG_UNIT_BYTES, 4096)};
        rows = {rows, cfg_row(REG_HEADER_BYTES, 64)};
        rows = {rows, req_row(OP_ALLOC, 1048575, 0, 1, full)};
        rows = {rows, req_row(OP_ALLOC, 0, 0, 0, none)};
        rows = {rows, cfg_row(REG_UNIT_BYTES, 8191)};
        rows = {rows, cfg_row(REG_HEADER_BYTES, 127)};
        rows = {rows, req_row(OP_ALLOC, 1000, 0, 0, none)};

        foreach (rows[i])
            if (rows[i].kind == ROW_CFG)
            begin
                req.valid <= 1'b0;
                write_reg(rows[i].idx, rows[i].data);
            end
            else
                send_txn(rows[i].op, rows[i].len, rows[i].off, rows[i].fixed, rows[i].want);

        for (int p = 0; p < 5; p++)
        begin
            req.valid <= 1'b0;
            write_reg(REG_UNIT_BYTES, CFG_DATA_W'(unit_tbl[p]));
            write_reg(REG_HEADER_BYTES, CFG_DATA_W'(hdr_tbl[p]));
            for (int i = 0; i < 80; i++)
            begin
                if (i % 20 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                if (p == 1 && i == 10)
                    long_hold = 1'b1;
                if (p == 2 && i == 40)
                begin
                    req.valid <= 1'b0;
                    while (grant_q.size() != 0)
                        @(posedge clk);
                end
                random_txn();
            end
        end
        req.valid <= 1'b0;
        burst = 1'b0;

        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
sv/bba_pkg.sv
sv/bba_req_if.sv
sv/bba_rsp_if.sv
sv/bba_ram.sv
sv/buddy_block_allocator.sv
sv/bba_checker.sv
test/buddy_block_allocator_tb.sv
